[hw/rtl/i2cms_pkg.sv]
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master line sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

  localparam int DATA_BITS   = 8;
  localparam int BIT_CNT_W   = $clog2(DATA_BITS);
  localparam int HOLD_W      = 16;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd720;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_STOP    = 3'd1,
    OP_TX_BYTE = 3'd2,
    OP_RX_BYTE = 3'd3,
    OP_TX_ACK  = 3'd4,
    OP_RX_ACK  = 3'd5
  } op_e;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_state_e;

  typedef struct packed {
    op_e                  op;
    logic [DATA_BITS-1:0] tx_byte;
    logic                 ack_out;
    logic [DATA_BITS-1:0] sda_samples;
  } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/i2cms_if.sv]
// ----------------------------------------------------------------------------
// i2cms_if
// Request channels of the sequencer: commands in, line phases out.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cms_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] tx_byte;
  logic       ack_out;
  logic [7:0] sda_samples;

  modport source (output valid, operation, tx_byte, ack_out, sda_samples, input ready);
  modport sink   (input valid, operation, tx_byte, ack_out, sda_samples, output ready);
endinterface

interface i2cms_phase_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sample_point;
  logic [7:0] rx_byte;
  logic       ack_seen;
  logic       last_phase;

  modport source (output valid, scl_level, sda_level, sample_point, rx_byte, ack_seen,
                  last_phase, input ready);
  modport sink   (input valid, scl_level, sda_level, sample_point, rx_byte, ack_seen,
                  last_phase, output ready);
endinterface

`default_nettype wire

[hw/rtl/i2cms_front.sv]
// ----------------------------------------------------------------------------
// i2cms_front
// Command intake: drops unused operation codes and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_front #(
  parameter int QUEUE_DEPTH = i2cms_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  i2cms_cmd_if.sink            cmd_i,
  output      logic            q_valid_o,
  output      i2cms_pkg::cmd_t q_data_o,
  input  wire logic            q_ready_i
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  i2cms_pkg::cmd_t mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            op_ok;
  logic            push, pop;
  i2cms_pkg::cmd_t entry;

  always_comb begin
    unique case (cmd_i.operation)
      i2cms_pkg::OP_START,
      i2cms_pkg::OP_STOP,
      i2cms_pkg::OP_TX_BYTE,
      i2cms_pkg::OP_RX_BYTE,
      i2cms_pkg::OP_TX_ACK,
      i2cms_pkg::OP_RX_ACK: op_ok = 1'b1;
      default:              op_ok = 1'b0;
    endcase
  end

  always_comb begin
    entry.op          = i2cms_pkg::op_e'(cmd_i.operation);
    entry.tx_byte     = cmd_i.tx_byte;
    entry.ack_out     = cmd_i.ack_out;
    entry.sda_samples = cmd_i.sda_samples;
  end

  assign cmd_i.ready = (count_q != CntW'(QUEUE_DEPTH));
  assign push        = cmd_i.valid && cmd_i.ready && op_ok;
  assign q_valid_o   = (count_q != '0);
  assign pop         = q_valid_o && q_ready_i;
  assign q_data_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/i2cms_back.sv]
// ----------------------------------------------------------------------------
// i2cms_back
// Phase sequencer: steps through a command's line phases, paces them with the
// programmed hold counter and registers each one on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire i2cms_pkg::cmd_t               q_data_i,
  output      logic                          q_ready_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [i2cms_pkg::HOLD_W-1:0]  cfg_wdata_i,
  i2cms_phase_if.source                      phase_o
);

  localparam int DB = i2cms_pkg::DATA_BITS;
  localparam int BW = i2cms_pkg::BIT_CNT_W;
  localparam int HW = i2cms_pkg::HOLD_W;

  i2cms_pkg::seq_state_e state_q, state_d;

  logic [HW-1:0] hold_q;
  logic [HW-1:0] hold_cnt_q, hold_cnt_d;
  i2cms_pkg::op_e op_q;
  logic [DB-1:0] tx_q, tx_d;
  logic [DB-1:0] smp_q, smp_d;
  logic [DB-1:0] rx_q, rx_d;
  logic          ack_q;
  logic [1:0]    step_q, step_d;
  logic [BW-1:0] bit_q, bit_d;
  logic          scl_q, scl_d;
  logic          sda_q, sda_d;
  logic          bit_last;

  logic          issue;
  logic          load;
  logic          ph_sample;
  logic [DB-1:0] ph_rx;
  logic          ph_ack;
  logic          ph_last;

  logic          out_valid_q;
  logic          out_scl_q, out_sda_q, out_sample_q, out_ack_q, out_last_q;
  logic [DB-1:0] out_rx_q;

  assign load     = (state_q == i2cms_pkg::SEQ_IDLE) && q_valid_i;
  assign q_ready_o = (state_q == i2cms_pkg::SEQ_IDLE);
  assign issue    = (state_q == i2cms_pkg::SEQ_RUN) && (hold_cnt_q == '0) &&
                    (!out_valid_q || phase_o.ready);
  assign bit_last = (bit_q == BW'(DB - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      i2cms_pkg::SEQ_IDLE: begin
        if (q_valid_i) begin
          state_d = i2cms_pkg::SEQ_RUN;
        end
      end
      i2cms_pkg::SEQ_RUN: begin
        if (issue && ph_last) begin
          state_d = i2cms_pkg::SEQ_IDLE;
        end
      end
      default: state_d = i2cms_pkg::SEQ_IDLE;
    endcase
  end

  // phase content
  always_comb begin
    scl_d     = scl_q;
    sda_d     = sda_q;
    tx_d      = tx_q;
    smp_d     = smp_q;
    rx_d      = rx_q;
    step_d    = step_q + 2'd1;
    bit_d     = bit_q;
    ph_sample = 1'b0;
    ph_rx     = '0;
    ph_ack    = 1'b0;
    ph_last   = 1'b0;
    unique case (op_q)
      i2cms_pkg::OP_START: begin
        unique case (step_q)
          2'd0:    sda_d = 1'b1;
          2'd1:    scl_d = 1'b1;
          2'd2:    sda_d = 1'b0;
          default: begin
            scl_d   = 1'b0;
            ph_last = 1'b1;
          end
        endcase
      end
      i2cms_pkg::OP_STOP: begin
        unique case (step_q)
          2'd0:    sda_d = 1'b0;
          2'd1:    scl_d = 1'b1;
          default: begin
            sda_d   = 1'b1;
            ph_last = 1'b1;
          end
        endcase
      end
      i2cms_pkg::OP_TX_BYTE: begin
        unique case (step_q)
          2'd0: begin
            sda_d = tx_q[DB-1];
            tx_d  = {tx_q[DB-2:0], 1'b0};
          end
          2'd1:    scl_d = 1'b1;
          default: begin
            scl_d   = 1'b0;
            ph_last = bit_last;
            step_d  = 2'd0;
            bit_d   = bit_q + 1'b1;
          end
        endcase
      end
      i2cms_pkg::OP_RX_BYTE: begin
        unique case (step_q)
          2'd3: begin
            sda_d  = 1'b1;
            step_d = 2'd0;
          end
          2'd0:    scl_d = 1'b1;
          2'd1: begin
            ph_sample = 1'b1;
            rx_d      = {rx_q[DB-2:0], smp_q[DB-1]};
            smp_d     = {smp_q[DB-2:0], 1'b0};
          end
          default: begin
            scl_d   = 1'b0;
            ph_last = bit_last;
            ph_rx   = bit_last ? rx_q : '0;
            step_d  = 2'd0;
            bit_d   = bit_q + 1'b1;
          end
        endcase
      end
      i2cms_pkg::OP_TX_ACK: begin
        unique case (step_q)
          2'd0:    sda_d = ack_q;
          2'd1:    scl_d = 1'b1;
          default: begin
            scl_d   = 1'b0;
            ph_last = 1'b1;
          end
        endcase
      end
      default: begin
        unique case (step_q)
          2'd3: begin
            sda_d  = 1'b1;
            step_d = 2'd0;
          end
          2'd0:    scl_d = 1'b1;
          2'd1: begin
            ph_sample = 1'b1;
            rx_d      = {rx_q[DB-2:0], smp_q[DB-1]};
          end
          default: begin
            scl_d   = 1'b0;
            ph_last = 1'b1;
            ph_ack  = rx_q[0];
          end
        endcase
      end
    endcase
  end

  always_comb begin
    hold_cnt_d = hold_cnt_q;
    if (issue) begin
      hold_cnt_d = hold_q - 1'b1;
    end else if (hold_cnt_q != '0) begin
      hold_cnt_d = hold_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= i2cms_pkg::SEQ_IDLE;
      hold_q      <= i2cms_pkg::HOLD_RESET;
      hold_cnt_q  <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      step_q      <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      hold_cnt_q <= hold_cnt_d;
      if (cfg_we_i) begin
        hold_q <= (cfg_wdata_i == '0) ? HW'(1) : cfg_wdata_i;
      end
      if (load) begin
        step_q <= ((q_data_i.op == i2cms_pkg::OP_RX_BYTE) ||
                   (q_data_i.op == i2cms_pkg::OP_RX_ACK)) ? 2'd3 : 2'd0;
        bit_q  <= '0;
      end else if (issue) begin
        step_q <= step_d;
        bit_q  <= bit_d;
        scl_q  <= scl_d;
        sda_q  <= sda_d;
      end
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (phase_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q  <= q_data_i.op;
      tx_q  <= q_data_i.tx_byte;
      ack_q <= q_data_i.ack_out;
      smp_q <= q_data_i.sda_samples;
      rx_q  <= '0;
    end else if (issue) begin
      tx_q  <= tx_d;
      smp_q <= smp_d;
      rx_q  <= rx_d;
    end
    if (issue) begin
      out_scl_q    <= scl_d;
      out_sda_q    <= sda_d;
      out_sample_q <= ph_sample;
      out_rx_q     <= ph_rx;
      out_ack_q    <= ph_ack;
      out_last_q   <= ph_last;
    end
  end

  assign phase_o.valid        = out_valid_q;
  assign phase_o.scl_level    = out_scl_q;
  assign phase_o.sda_level    = out_sda_q;
  assign phase_o.sample_point = out_sample_q;
  assign phase_o.rx_byte      = out_rx_q;
  assign phase_o.ack_seen     = out_ack_q;
  assign phase_o.last_phase   = out_last_q;

endmodule

`default_nettype wire

[hw/rtl/i2c_master_bit_sequencer_core.sv]
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// I2C master line sequencer: turns bus commands into timed SCL/SDA phases.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  cmd_i     in    valid/ready        operation, tx_byte, ack_out, sda_samples
//  phase_o   out   valid/ready        scl/sda level, sample_point, rx_byte,
//                                     ack_seen, last_phase
//  cfg       in    cfg_we_i           cfg_wdata_i = phase_hold_cycles
//
//  a command gives 3 to 25 phases; phases are paced by the hold counter of
//  the sequencer, which reloads from phase_hold_cycles as each phase issues
//  the command queue takes new requests while the sequencer runs
//  a stalled output freezes the sequencer; reset returns both lines released
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer_core #(
  parameter int QUEUE_DEPTH = i2cms_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  i2cms_cmd_if.sink                          cmd_i,
  i2cms_phase_if.source                      phase_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [i2cms_pkg::HOLD_W-1:0]  cfg_wdata_i
);

  logic            q_valid;
  logic            q_ready;
  i2cms_pkg::cmd_t q_data;

  i2cms_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .q_valid_o(q_valid),
    .q_data_o (q_data),
    .q_ready_i(q_ready)
  );

  i2cms_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_ready_o  (q_ready),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .phase_o    (phase_o)
  );

endmodule

`default_nettype wire

[hw/rtl/i2cms_checker.sv]
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks of the sequencer output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       scl_i,
  input wire logic       sample_i,
  input wire logic [7:0] rx_i,
  input wire logic       ack_i,
  input wire logic       last_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output request dropped while stalled");

  a_sample_scl_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && sample_i |-> scl_i)
    else $error("sample taken with scl low");

  a_sample_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && sample_i |-> !last_i)
    else $error("sample on final phase");

  a_rx_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (rx_i != 8'd0) |-> last_i)
    else $error("received byte outside final phase");

  a_ack_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ack_i |-> last_i && !scl_i)
    else $error("ack outside final scl-low phase");

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(phase_o.valid),
  .out_ready_i(phase_o.ready),
  .scl_i      (phase_o.scl_level),
  .sample_i   (phase_o.sample_point),
  .rx_i       (phase_o.rx_byte),
  .ack_i      (phase_o.ack_seen),
  .last_i     (phase_o.last_phase)
);

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C master line sequencer. Commands are sent in
// bursts while the phase channel stalls on its own pattern. Every phase that
// comes out is compared with the next one from a line-level predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  typedef struct {
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       ack_out;
    logic [7:0] sda_samples;
  } command_t;

  typedef struct {
    logic       scl_level;
    logic       sda_level;
    logic       sample_point;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       last_phase;
  } line_phase_t;

  class phase_scoreboard;
    line_phase_t expected_phases[$];
    logic        scl_line;
    logic        sda_line;
    logic [7:0]  rx_shift;
    int unsigned hold_cycles;
    int unsigned mismatches;
    int unsigned phases_checked;
    int unsigned commands_noted;

    function new();
      scl_line       = 1'b1;
      sda_line       = 1'b1;
      rx_shift       = 8'h00;
      hold_cycles    = 32'(i2cms_pkg::HOLD_RESET);
      mismatches     = 0;
      phases_checked = 0;
      commands_noted = 0;
    endfunction

    function void set_hold(logic [i2cms_pkg::HOLD_W-1:0] value);
      hold_cycles = (value == '0) ? 1 : 32'(value);
    endfunction

    function void add_phase(logic sample, logic last, logic [7:0] rx, logic ack);
      line_phase_t p;
      p.scl_level    = scl_line;
      p.sda_level    = sda_line;
      p.sample_point = sample;
      p.rx_byte      = rx;
      p.ack_seen     = ack;
      p.last_phase   = last;
      expected_phases.push_back(p);
    endfunction

    function void drive_sda(logic level, logic last);
      sda_line = level;
      add_phase(1'b0, last, 8'h00, 1'b0);
    endfunction

    function void drive_scl(logic level, logic last, logic [7:0] rx, logic ack);
      scl_line = level;
      add_phase(1'b0, last, rx, ack);
    endfunction

    function void predict_line_phases(command_t c);
      case (c.operation)
        i2cms_pkg::OP_START: begin
          drive_sda(1'b1, 1'b0);
          drive_scl(1'b1, 1'b0, 8'h00, 1'b0);
          drive_sda(1'b0, 1'b0);
          drive_scl(1'b0, 1'b1, 8'h00, 1'b0);
        end
        i2cms_pkg::OP_STOP: begin
          drive_sda(1'b0, 1'b0);
          drive_scl(1'b1, 1'b0, 8'h00, 1'b0);
          drive_sda(1'b1, 1'b1);
        end
        i2cms_pkg::OP_TX_BYTE: begin
          for (int i = i2cms_pkg::DATA_BITS - 1; i >= 0; i--) begin
            drive_sda(c.tx_byte[i], 1'b0);
            drive_scl(1'b1, 1'b0, 8'h00, 1'b0);
            drive_scl(1'b0, i == 0, 8'h00, 1'b0);
          end
        end
        i2cms_pkg::OP_RX_BYTE: begin
          rx_shift = 8'h00;
          drive_sda(1'b1, 1'b0);
          for (int i = i2cms_pkg::DATA_BITS - 1; i >= 0; i--) begin
            drive_scl(1'b1, 1'b0, 8'h00, 1'b0);
            rx_shift = {rx_shift[6:0], c.sda_samples[i]};
            add_phase(1'b1, 1'b0, 8'h00, 1'b0);
            drive_scl(1'b0, i == 0, (i == 0) ? rx_shift : 8'h00, 1'b0);
          end
        end
        i2cms_pkg::OP_TX_ACK: begin
          drive_sda(c.ack_out, 1'b0);
          drive_scl(1'b1, 1'b0, 8'h00, 1'b0);
          drive_scl(1'b0, 1'b1, 8'h00, 1'b0);
        end
        i2cms_pkg::OP_RX_ACK: begin
          drive_sda(1'b1, 1'b0);
          drive_scl(1'b1, 1'b0, 8'h00, 1'b0);
          add_phase(1'b1, 1'b0, 8'h00, 1'b0);
          drive_scl(1'b0, 1'b1, 8'h00, c.sda_samples[7]);
        end
        default: begin
        end
      endcase
    endfunction

    function void note_command(command_t c);
      commands_noted++;
      predict_line_phases(c);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_phase(line_phase_t got);
      line_phase_t want;
      phases_checked++;
      if (expected_phases.size() == 0) begin
        $error("line phase with no request pending: scl %0b sda %0b",
               got.scl_level, got.sda_level);
        mismatches++;
        return;
      end
      want = expected_phases.pop_front();
      compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
      compare_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
      compare_field("sample_point", 8'(want.sample_point), 8'(got.sample_point));
      compare_field("rx_byte", want.rx_byte, got.rx_byte);
      compare_field("ack_seen", 8'(want.ack_seen), 8'(got.ack_seen));
      compare_field("last_phase", 8'(want.last_phase), 8'(got.last_phase));
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [i2cms_pkg::HOLD_W-1:0] cfg_wdata_i;

  i2cms_cmd_if   cmd_if ();
  i2cms_phase_if phase_if ();

  i2c_master_bit_sequencer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_if),
    .phase_o     (phase_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  phase_scoreboard board = new();

  int unsigned burst_left;
  int unsigned idle_cycles;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // phase channel back-pressure
  initial begin
    logic [15:0] stall_word;
    int unsigned stall_pos;
    int unsigned pattern_age;
    phase_if.ready = 1'b0;
    stall_word     = 16'hffff;
    stall_pos      = 0;
    pattern_age    = 0;
    forever begin
      @(negedge clk_i);
      if (pattern_age == 0) begin
        pattern_age = 48;
        if ($urandom_range(0, 2) == 0) stall_word = 16'hffff;
        else stall_word = 16'($urandom) | 16'h0001;
      end
      pattern_age--;
      phase_if.ready <= stall_word[stall_pos];
      stall_pos = (stall_pos + 1) % 16;
    end
  end

  always @(posedge clk_i) begin
    line_phase_t got;
    if (rst_ni && phase_if.valid && phase_if.ready) begin
      got.scl_level    = phase_if.scl_level;
      got.sda_level    = phase_if.sda_level;
      got.sample_point = phase_if.sample_point;
      got.rx_byte      = phase_if.rx_byte;
      got.ack_seen     = phase_if.ack_seen;
      got.last_phase   = phase_if.last_phase;
      board.check_phase(got);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (phase_if.valid && phase_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= 4 * board.hold_cycles + 2000) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  function automatic command_t random_command(logic [2:0] op);
    command_t c;
    c.operation   = op;
    c.tx_byte     = 8'($urandom);
    c.ack_out     = 1'($urandom);
    c.sda_samples = 8'($urandom);
    return c;
  endfunction

  function automatic command_t make_command(logic [2:0] op, logic [7:0] tx, logic ack,
                                            logic [7:0] samples);
    command_t c;
    c.operation   = op;
    c.tx_byte     = tx;
    c.ack_out     = ack;
    c.sda_samples = samples;
    return c;
  endfunction

  // entered and left at a falling edge
  task automatic send_command(input command_t c);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    cmd_if.valid       <= 1'b1;
    cmd_if.operation   <= c.operation;
    cmd_if.tx_byte     <= c.tx_byte;
    cmd_if.ack_out     <= c.ack_out;
    cmd_if.sda_samples <= c.sda_samples;
    do @(posedge clk_i); while (!cmd_if.ready);
    board.note_command(c);
    @(negedge clk_i);
  endtask

  // the hold counter still runs after the last phase, so the wait covers the hold time
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    while (board.expected_phases.size() != 0) @(posedge clk_i);
    repeat (board.hold_cycles + 16) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_hold(input logic [i2cms_pkg::HOLD_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_hold(value);
  endtask

  // whole transfers with random content, with stray commands mixed in
  task automatic run_random_transfers(input int unsigned target);
    int unsigned sent;
    int unsigned data_n;
    logic [2:0]  op;
    command_t    c;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 7) == 0) begin
        op = 3'($urandom_range(0, 7));
        send_command(random_command(op));
        if (op <= i2cms_pkg::OP_RX_ACK) sent++;
      end else begin
        send_command(random_command(i2cms_pkg::OP_START));
        c = random_command(i2cms_pkg::OP_TX_BYTE);
        send_command(c);
        send_command(random_command(i2cms_pkg::OP_RX_ACK));
        data_n = $urandom_range(1, 3);
        repeat (data_n) begin
          if (c.tx_byte[0]) begin
            send_command(random_command(i2cms_pkg::OP_RX_BYTE));
            send_command(random_command(i2cms_pkg::OP_TX_ACK));
          end else begin
            send_command(random_command(i2cms_pkg::OP_TX_BYTE));
            send_command(random_command(i2cms_pkg::OP_RX_ACK));
          end
        end
        send_command(random_command(i2cms_pkg::OP_STOP));
        sent += 4 + 2 * data_n;
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    cmd_if.valid       = 1'b0;
    cmd_if.operation   = i2cms_pkg::OP_START;
    cmd_if.tx_byte     = 8'h00;
    cmd_if.ack_out     = 1'b0;
    cmd_if.sda_samples = 8'h00;
    burst_left         = 0;
    idle_cycles        = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset hold value, field extremes and every command
    send_command(make_command(i2cms_pkg::OP_START, 8'h00, 1'b0, 8'h00));
    send_command(make_command(i2cms_pkg::OP_TX_BYTE, 8'h00, 1'b1, 8'hff));
    send_command(make_command(i2cms_pkg::OP_RX_ACK, 8'hff, 1'b1, 8'h00));
    send_command(make_command(i2cms_pkg::OP_TX_BYTE, 8'hff, 1'b0, 8'h00));
    send_command(make_command(i2cms_pkg::OP_RX_ACK, 8'h00, 1'b0, 8'h80));
    send_command(make_command(i2cms_pkg::OP_TX_BYTE, 8'ha5, 1'b0, 8'h7f));
    send_command(make_command(i2cms_pkg::OP_RX_ACK, 8'h00, 1'b0, 8'hff));
    send_command(make_command(i2cms_pkg::OP_RX_BYTE, 8'hff, 1'b1, 8'h00));
    send_command(make_command(i2cms_pkg::OP_TX_ACK, 8'hff, 1'b0, 8'hff));
    send_command(make_command(i2cms_pkg::OP_RX_BYTE, 8'h00, 1'b0, 8'hff));
    send_command(make_command(i2cms_pkg::OP_TX_ACK, 8'h00, 1'b1, 8'h00));
    send_command(make_command(i2cms_pkg::OP_RX_BYTE, 8'h3c, 1'b1, 8'h5a));
    // unused codes leave the lines alone
    send_command(make_command(OP_RSVD_6, 8'hff, 1'b1, 8'hff));
    send_command(make_command(OP_RSVD_7, 8'h00, 1'b0, 8'h00));
    send_command(make_command(i2cms_pkg::OP_STOP, 8'h00, 1'b0, 8'h00));
    // out-of-order commands on a stopped bus
    send_command(make_command(i2cms_pkg::OP_STOP, 8'hff, 1'b1, 8'hff));
    send_command(make_command(i2cms_pkg::OP_TX_ACK, 8'h00, 1'b1, 8'h00));
    send_command(make_command(i2cms_pkg::OP_START, 8'hff, 1'b1, 8'hff));
    wait_idle();

    // zero hold is taken as one
    write_hold('0);
    run_random_transfers(30);
    wait_idle();

    write_hold(16'hffff);
    send_command(random_command(i2cms_pkg::OP_STOP));
    wait_idle();

    write_hold(16'd3);
    run_random_transfers(30);
    wait_idle();

    write_hold(16'd1);
    run_random_transfers(20);
    wait_idle();
    repeat (2 * board.hold_cycles + 16) @(posedge clk_i);

    $display("tb: %0d commands sent, %0d line phases checked, %0d mismatches",
             board.commands_noted, board.phases_checked, board.mismatches);
    $display("tb: hold settings covered: 720 after reset, 0, 65535, 3 and 1");
    if (board.mismatches == 0 && board.expected_phases.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
